/* sv/gradient_noise_2d_assert.svh */
// Assertion macros for the gradient noise block.
// Included by the top level; no other dependencies.
`ifndef GRADIENT_NOISE_2D_ASSERT_SVH
`define GRADIENT_NOISE_2D_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GN2D_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define GN2D_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/gn2d_pkg.sv */
// Shared constants for the gradient noise pipeline.
// No dependencies.
package gn2d_pkg;

    localparam int CELL_SHIFT = 4;
    localparam int FRAC_BITS  = 8;
    localparam int PHASE_BITS = 10;
    localparam int TOT_SHIFT  = FRAC_BITS + CELL_SHIFT;

    localparam int SEED_W   = 30;
    localparam int CELL_W   = 32 - TOT_SHIFT;
    localparam int CORNER_W = CELL_W + 1;

    localparam logic [31:0] FRAC_MASK = 32'((64'd1 << TOT_SHIFT) - 64'd1);

    // Pipeline: stage 0 cell split, 1-5 hash, 6-10 sine, 11 dot, 12-13 lerp
    localparam int NUM_STAGES  = 14;
    localparam int HASH_FIRST  = 1;
    localparam int SINE_FIRST  = 6;
    localparam int DOT_STAGE   = 11;
    localparam int LERPX_STAGE = 12;
    localparam int LERPY_STAGE = 13;

    // Register indexes on paddr[3:2]
    localparam logic [1:0] REG_SEED_A = 2'd0;
    localparam logic [1:0] REG_SEED_B = 2'd1;
    localparam logic [1:0] REG_SEED_C = 2'd2;

    // Quarter-wave polynomial coefficients, Q14
    localparam logic [14:0] SIN_C1  = 15'd25736;
    localparam logic [13:0] SIN_C3  = 14'd10512;
    localparam logic [10:0] SIN_C5  = 11'd1160;
    localparam logic [14:0] SIN_ONE = 15'd16384;
    localparam logic [15:0] QUARTER_TURN = 16'd16384;

    typedef logic [4:0] stage_en_t;

endpackage

/* sv/gradient_noise_2d.sv */
// 2D gradient noise, one sample per clock unless m_ready stalls: a 14-stage
// pipeline, four corner hashes, eight sine units, dot products, linear blending.
// Depends on gn2d_pkg, gn2d_hash, gn2d_sine and gradient_noise_2d_assert.svh.
//
// Throughput is one item per clock while m_ready keeps the output draining; the
// pipeline depth comes from the split 64-bit hash multiplies (five stages) and the
// quarter-wave sine polynomial (five stages). Each stage has its own valid
// bit, so bubbles close up and input is taken while a result waits at m_.
// Seeds reset to zero and should be written only while the pipeline is empty.
module gradient_noise_2d (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_x_pos,
    input  logic signed [31:0] s_y_pos,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_noise_value
);

    `include "gradient_noise_2d_assert.svh"

    localparam int NS = gn2d_pkg::NUM_STAGES;
    localparam int CW = gn2d_pkg::CELL_W;
    localparam int KW = gn2d_pkg::CORNER_W;
    localparam int SW = gn2d_pkg::SEED_W;

    // Config registers
    logic [SW-1:0] seed_a_reg, seed_b_reg, seed_c_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_a_reg <= '0;
            seed_b_reg <= '0;
            seed_c_reg <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                gn2d_pkg::REG_SEED_A: seed_a_reg <= pwdata[SW-1:0];
                gn2d_pkg::REG_SEED_B: seed_b_reg <= pwdata[SW-1:0];
                gn2d_pkg::REG_SEED_C: seed_c_reg <= pwdata[SW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            gn2d_pkg::REG_SEED_A: prdata = 32'(seed_a_reg);
            gn2d_pkg::REG_SEED_B: prdata = 32'(seed_b_reg);
            gn2d_pkg::REG_SEED_C: prdata = 32'(seed_c_reg);
            default:              prdata = '0;
        endcase
    end

    // Stage valid bits and per-stage load enables
    logic [NS-1:0] valid_reg, valid_next, stage_rdy;

    always_comb begin
        stage_rdy[NS-1] = !valid_reg[NS-1] || m_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            stage_rdy[k] = !valid_reg[k] || stage_rdy[k+1];
        end
        valid_next = valid_reg;
        if (stage_rdy[0]) begin
            valid_next[0] = s_valid;
        end
        for (int k = 1; k < NS; k++) begin
            if (stage_rdy[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_rdy[0];
    assign m_valid = valid_reg[NS-1];

    // Stage 0: cell split
    logic signed [CW-1:0] x0_reg, y0_reg;
    logic [47:0]          fxw, fyw;
    logic [15:0]          fx_d [gn2d_pkg::LERPX_STAGE];
    logic [15:0]          fy_d [gn2d_pkg::LERPY_STAGE];

    assign fxw = ({16'd0, s_x_pos & gn2d_pkg::FRAC_MASK} << 16) >> gn2d_pkg::TOT_SHIFT;
    assign fyw = ({16'd0, s_y_pos & gn2d_pkg::FRAC_MASK} << 16) >> gn2d_pkg::TOT_SHIFT;

    always_ff @(posedge aclk) begin
        if (stage_rdy[0]) begin
            x0_reg  <= CW'(s_x_pos >>> gn2d_pkg::TOT_SHIFT);
            y0_reg  <= CW'(s_y_pos >>> gn2d_pkg::TOT_SHIFT);
            fx_d[0] <= fxw[15:0];
            fy_d[0] <= fyw[15:0];
        end
        for (int k = 1; k < gn2d_pkg::LERPX_STAGE; k++) begin
            if (stage_rdy[k]) fx_d[k] <= fx_d[k-1];
        end
        for (int k = 1; k < gn2d_pkg::LERPY_STAGE; k++) begin
            if (stage_rdy[k]) fy_d[k] <= fy_d[k-1];
        end
    end

    // Corners in order 00, 10, 01, 11
    logic signed [KW-1:0] cx [4];
    logic signed [KW-1:0] cy [4];
    logic [gn2d_pkg::PHASE_BITS-1:0] phase [4];
    logic [15:0]          turn_s [4];
    logic [15:0]          turn_c [4];
    logic signed [15:0]   gs [4];
    logic signed [15:0]   gc [4];

    assign cx[0] = KW'(x0_reg);
    assign cx[1] = KW'(x0_reg) + KW'(1);
    assign cx[2] = cx[0];
    assign cx[3] = cx[1];
    assign cy[0] = KW'(y0_reg);
    assign cy[1] = cy[0];
    assign cy[2] = KW'(y0_reg) + KW'(1);
    assign cy[3] = cy[2];

    for (genvar c = 0; c < 4; c++) begin : g_corner
        gn2d_hash u_hash (
            .aclk     (aclk),
            .stage_en (stage_rdy[gn2d_pkg::HASH_FIRST +: 5]),
            .cx       (cx[c]),
            .cy       (cy[c]),
            .seed_a   (seed_a_reg),
            .seed_b   (seed_b_reg),
            .seed_c   (seed_c_reg),
            .phase    (phase[c])
        );

        assign turn_s[c] = 16'(phase[c]) << (16 - gn2d_pkg::PHASE_BITS);
        assign turn_c[c] = turn_s[c] + gn2d_pkg::QUARTER_TURN;

        gn2d_sine u_sin (
            .aclk     (aclk),
            .stage_en (stage_rdy[gn2d_pkg::SINE_FIRST +: 5]),
            .turn     (turn_s[c]),
            .value    (gs[c])
        );

        gn2d_sine u_cos (
            .aclk     (aclk),
            .stage_en (stage_rdy[gn2d_pkg::SINE_FIRST +: 5]),
            .turn     (turn_c[c]),
            .value    (gc[c])
        );
    end

    // Stage 11: dot products. fx - 1.0 in 18 bits is {2'b11, fx}.
    logic signed [17:0] dx [4];
    logic signed [17:0] dy [4];
    logic signed [34:0] dsum [4];
    logic signed [20:0] n_reg [4];
    logic [15:0]        fx10, fy10;

    assign fx10  = fx_d[gn2d_pkg::DOT_STAGE-1];
    assign fy10  = fy_d[gn2d_pkg::DOT_STAGE-1];
    assign dx[0] = $signed({2'b00, fx10});
    assign dx[1] = $signed({2'b11, fx10});
    assign dx[2] = dx[0];
    assign dx[3] = dx[1];
    assign dy[0] = $signed({2'b00, fy10});
    assign dy[1] = dy[0];
    assign dy[2] = $signed({2'b11, fy10});
    assign dy[3] = dy[2];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            dsum[c] = 35'(dx[c]) * 35'(gc[c]) + 35'(dy[c]) * 35'(gs[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_rdy[gn2d_pkg::DOT_STAGE]) begin
            for (int c = 0; c < 4; c++) begin
                n_reg[c] <= 21'(dsum[c] >>> 14);
            end
        end
    end

    // Stage 12: blend along x
    logic signed [21:0] dn0, dn1;
    logic signed [38:0] pm0, pm1;
    logic signed [23:0] ix0_reg, ix1_reg;
    logic signed [16:0] sfx, sfy;

    assign sfx = $signed({1'b0, fx_d[gn2d_pkg::LERPX_STAGE-1]});
    assign dn0 = 22'(n_reg[1]) - 22'(n_reg[0]);
    assign dn1 = 22'(n_reg[3]) - 22'(n_reg[2]);
    assign pm0 = 39'(dn0) * 39'(sfx);
    assign pm1 = 39'(dn1) * 39'(sfx);

    always_ff @(posedge aclk) begin
        if (stage_rdy[gn2d_pkg::LERPX_STAGE]) begin
            ix0_reg <= 24'(n_reg[0]) + 24'(pm0 >>> 16);
            ix1_reg <= 24'(n_reg[2]) + 24'(pm1 >>> 16);
        end
    end

    // Stage 13: blend along y, scale to Q14 and saturate
    logic signed [24:0] di;
    logic signed [41:0] pmy;
    logic signed [26:0] vq16;
    logic signed [24:0] vq14;
    logic signed [15:0] noise_reg, noise_next;

    assign sfy  = $signed({1'b0, fy_d[gn2d_pkg::LERPY_STAGE-1]});
    assign di   = 25'(ix1_reg) - 25'(ix0_reg);
    assign pmy  = 42'(di) * 42'(sfy);
    assign vq16 = 27'(ix0_reg) + 27'(pmy >>> 16);
    assign vq14 = 25'(vq16 >>> 2);

    always_comb begin
        if (vq14 > 25'sd32767) begin
            noise_next = 16'sh7FFF;
        end else if (vq14 < -25'sd32768) begin
            noise_next = -16'sh8000;
        end else begin
            noise_next = 16'(vq14);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_rdy[gn2d_pkg::LERPY_STAGE]) begin
            noise_reg <= noise_next;
        end
    end

    assign m_noise_value = noise_reg;

    `GN2D_ASSERT_NOW(a_empty_takes_item, aclk, aresetn, !valid_reg[0], s_ready,
        "input stage empty but input not ready")
    `GN2D_ASSERT_NEXT(a_seed_a_write, aclk, aresetn,
        cfg_wr && paddr[3:2] == gn2d_pkg::REG_SEED_A,
        seed_a_reg == $past(pwdata[SW-1:0]), "seed_a write lost")
    `GN2D_ASSERT_NEXT(a_no_drop, aclk, aresetn, valid_reg[NS-2] && !stage_rdy[NS-1],
        valid_reg[NS-2] && valid_reg[NS-1], "item dropped while output stalled")

endmodule

/* sv/gn2d_hash.sv */
// Five-stage corner hash: a direct seed A multiply, then seeds B/C with 64-bit
// wrapping multiplies split into 32-bit halves. Depends on gn2d_pkg.
module gn2d_hash (
    input  logic                                 aclk,
    input  gn2d_pkg::stage_en_t                  stage_en,
    input  logic signed [gn2d_pkg::CORNER_W-1:0] cx,
    input  logic signed [gn2d_pkg::CORNER_W-1:0] cy,
    input  logic [gn2d_pkg::SEED_W-1:0]          seed_a,
    input  logic [gn2d_pkg::SEED_W-1:0]          seed_b,
    input  logic [gn2d_pkg::SEED_W-1:0]          seed_c,
    output logic [gn2d_pkg::PHASE_BITS-1:0]      phase
);

    localparam int AW = gn2d_pkg::CORNER_W + gn2d_pkg::SEED_W + 1;
    localparam int PW = 32 + gn2d_pkg::SEED_W;

    logic signed [AW-1:0]                 a1_reg, a1_next;
    logic signed [gn2d_pkg::CORNER_W-1:0] cy1_reg;
    logic [63:0]  a2_reg, a64, b_mix;
    logic [PW-1:0] plo2_reg, plo_next, phi_full;
    logic [31:0]  phi2_reg;
    logic [63:0]  bb, am3_reg, am_next;
    logic [PW-1:0] qlo4_reg, qlo_next, qhi_full;
    logic [31:0]  qhi4_reg;
    logic [63:0]  prod;
    logic [gn2d_pkg::PHASE_BITS-1:0] phase_reg;

    function automatic logic [63:0] mix64(input logic [63:0] v);
        mix64 = {v[31:0] | {32{v[63]}}, v[63:32]};
    endfunction

    assign a1_next  = AW'(cx) * AW'($signed({1'b0, seed_a}));
    assign a64      = 64'(a1_reg);
    assign b_mix    = 64'(cy1_reg) ^ mix64(a64);
    assign plo_next = PW'(b_mix[31:0]) * PW'(seed_b);
    assign phi_full = PW'(b_mix[63:32]) * PW'(seed_b);
    assign bb       = 64'(plo2_reg) + {phi2_reg, 32'd0};
    assign am_next  = a2_reg & mix64(bb);
    assign qlo_next = PW'(am3_reg[31:0]) * PW'(seed_c);
    assign qhi_full = PW'(am3_reg[63:32]) * PW'(seed_c);
    assign prod     = 64'(qlo4_reg) + {qhi4_reg, 32'd0};

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            a1_reg  <= a1_next;
            cy1_reg <= cy;
        end
        if (stage_en[1]) begin
            a2_reg   <= a64;
            plo2_reg <= plo_next;
            phi2_reg <= phi_full[31:0];
        end
        if (stage_en[2]) begin
            am3_reg <= am_next;
        end
        if (stage_en[3]) begin
            qlo4_reg <= qlo_next;
            qhi4_reg <= qhi_full[31:0];
        end
        if (stage_en[4]) begin
            phase_reg <= prod[63 -: gn2d_pkg::PHASE_BITS];
        end
    end

    assign phase = phase_reg;

endmodule

/* sv/gn2d_sine.sv */
// Five-stage quarter-wave sine on a 16-bit turn, Q14 result.
// Depends on gn2d_pkg.
module gn2d_sine (
    input  logic                aclk,
    input  gn2d_pkg::stage_en_t stage_en,
    input  logic [15:0]         turn,
    output logic signed [15:0]  value
);

    logic [14:0] z_next, z6_reg, z7_reg, z8_reg, z9_reg;
    logic        neg6_reg, neg7_reg, neg8_reg, neg9_reg;
    logic [29:0] zz;
    logic [14:0] z2_7_reg, z2_8_reg;
    logic [25:0] p5;
    logic [13:0] inner8_reg;
    logic [28:0] p3;
    logic [14:0] outer9_reg;
    logic [29:0] p1;
    logic [15:0] s_mag;
    logic signed [15:0] value_reg;

    assign z_next = turn[14] ? 15'(gn2d_pkg::SIN_ONE - {1'b0, turn[13:0]})
                             : {1'b0, turn[13:0]};
    assign zz    = 30'(z6_reg) * 30'(z6_reg);
    assign p5    = 26'(z2_7_reg) * 26'(gn2d_pkg::SIN_C5);
    assign p3    = 29'(z2_8_reg) * 29'(inner8_reg);
    assign p1    = 30'(z9_reg) * 30'(outer9_reg);
    assign s_mag = p1[29:14];

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            z6_reg   <= z_next;
            neg6_reg <= turn[15];
        end
        if (stage_en[1]) begin
            z2_7_reg <= zz[28:14];
            z7_reg   <= z6_reg;
            neg7_reg <= neg6_reg;
        end
        if (stage_en[2]) begin
            inner8_reg <= gn2d_pkg::SIN_C3 - 14'(p5[25:14]);
            z2_8_reg   <= z2_7_reg;
            z8_reg     <= z7_reg;
            neg8_reg   <= neg7_reg;
        end
        if (stage_en[3]) begin
            outer9_reg <= gn2d_pkg::SIN_C1 - p3[28:14];
            z9_reg     <= z8_reg;
            neg9_reg   <= neg8_reg;
        end
        if (stage_en[4]) begin
            value_reg <= neg9_reg ? $signed(16'd0 - s_mag) : $signed(s_mag);
        end
    end

    assign value = value_reg;

endmodule
